### hdl/pfr_pkg.sv
// Shared constants, codes and types for the page frame replacement block.
// No dependencies; imported by pfr_frame_store and page_frame_replacement.
package pfr_pkg;

    // Default table geometry
    localparam int PFR_FRAMES    = 8;
    localparam int PFR_PAGE_BITS = 16;

    // Fixed port and state widths
    localparam int PFR_PAGE_IN_W   = 16;
    localparam int PFR_FRAME_OUT_W = 3;
    localparam int PFR_STAMP_W     = 32;
    localparam int PFR_COUNT_W     = 32;
    localparam int PFR_OUTCOME_W   = 2;

    // Outcome codes
    localparam logic [PFR_OUTCOME_W-1:0] PFR_OUT_HIT     = 2'd0;
    localparam logic [PFR_OUTCOME_W-1:0] PFR_OUT_FILL    = 2'd1;
    localparam logic [PFR_OUTCOME_W-1:0] PFR_OUT_REPLACE = 2'd2;

    // Write strobes from the sequencer to the frame store
    typedef struct packed {
        logic page_we;
        logic stamp_we;
    } t_store_wr;

endpackage

### hdl/page_frame_replacement.sv
// Page frame replacement: one page reference per transaction, LRU or FIFO eviction.
// Sequence: accept, then a scan of one frame per cycle that stops at a hit, at the first
// empty frame or after the last frame, then an update that waits for a free output register
// and loads it. A new reference is accepted only in idle, after the last update; the scan
// is serial over the single frame store read port and the shared stamp comparator.
// Reset (synchronous, active low) empties all frames, clears counters, selects LRU.
module page_frame_replacement
    import pfr_pkg::*;
#(
    parameter int FRAMES    = PFR_FRAMES,
    parameter int PAGE_BITS = PFR_PAGE_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_data,
    // page reference channel
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [PFR_PAGE_IN_W-1:0]   i_page_number,
    // result channel
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [PFR_OUTCOME_W-1:0]   o_outcome,
    output logic [PFR_FRAME_OUT_W-1:0] o_frame_index,
    output logic                       o_evicted_valid,
    output logic [PFR_PAGE_IN_W-1:0]   o_evicted_page,
    output logic [PFR_COUNT_W-1:0]     o_replacement_total
);

    localparam int IDX_W = $clog2(FRAMES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAMES - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    // control registers
    logic [1:0]             r_state, n_state;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [FRAMES-1:0]      r_valid, n_valid;
    logic [PFR_STAMP_W-1:0] r_seq, n_seq;
    logic [PFR_COUNT_W-1:0] r_repl_cnt, n_repl_cnt;
    logic                   r_refresh, n_refresh;
    logic                   r_o_valid, n_o_valid;

    // payload registers
    logic [PAGE_BITS-1:0]       r_page;
    logic [IDX_W-1:0]           r_best_idx, n_best_idx;
    logic [PFR_STAMP_W-1:0]     r_best_stamp, n_best_stamp;
    logic [PAGE_BITS-1:0]       r_best_page, n_best_page;
    logic [IDX_W-1:0]           r_slot, n_slot;
    logic [PFR_OUTCOME_W-1:0]   r_outcome, n_outcome;
    logic [PFR_OUTCOME_W-1:0]   r_o_outcome;
    logic [PFR_FRAME_OUT_W-1:0] r_o_frame;
    logic                       r_o_ev_valid;
    logic [PFR_PAGE_IN_W-1:0]   r_o_ev_page;

    // frame store interface
    logic [PAGE_BITS-1:0]   w_rd_page;
    logic [PFR_STAMP_W-1:0] w_rd_stamp;
    t_store_wr              w_wr;

    logic w_accept, w_match, w_empty, w_older, w_fire, w_is_repl;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;

    // shared compare unit: one frame against the pending page and the oldest stamp
    assign w_match = r_valid[r_idx] && (w_rd_page == r_page);
    assign w_empty = !r_valid[r_idx];
    assign w_older = (r_idx == '0) || (w_rd_stamp < r_best_stamp);

    // update fires once the output register is free
    assign w_fire    = (r_state == ST_UPD) && (!r_o_valid || i_ready);
    assign w_is_repl = (r_outcome == PFR_OUT_REPLACE);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_valid      = r_valid;
        n_seq        = r_seq;
        n_repl_cnt   = r_repl_cnt;
        n_refresh    = r_refresh;
        n_o_valid    = r_o_valid && !i_ready;
        n_best_idx   = r_best_idx;
        n_best_stamp = r_best_stamp;
        n_best_page  = r_best_page;
        n_slot       = r_slot;
        n_outcome    = r_outcome;
        w_wr         = '0;

        if (i_cfg_we) begin
            n_refresh = i_cfg_data;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_idx   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_match) begin
                    n_slot    = r_idx;
                    n_outcome = PFR_OUT_HIT;
                    n_state   = ST_UPD;
                end else if (w_empty) begin
                    n_slot    = r_idx;
                    n_outcome = PFR_OUT_FILL;
                    n_state   = ST_UPD;
                end else begin
                    // track the oldest resident frame, lowest index on a tie
                    if (w_older) begin
                        n_best_idx   = r_idx;
                        n_best_stamp = w_rd_stamp;
                        n_best_page  = w_rd_page;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_slot    = n_best_idx;
                        n_outcome = PFR_OUT_REPLACE;
                        n_state   = ST_UPD;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_UPD: begin
                if (w_fire) begin
                    w_wr.page_we  = (r_outcome != PFR_OUT_HIT);
                    w_wr.stamp_we = (r_outcome != PFR_OUT_HIT) || r_refresh;
                    if (r_outcome == PFR_OUT_FILL) begin
                        n_valid[r_slot] = 1'b1;
                    end
                    if (w_is_repl && (r_repl_cnt != '1)) begin
                        n_repl_cnt = r_repl_cnt + 1'b1;
                    end
                    n_seq     = r_seq + 1'b1;
                    n_o_valid = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_idx      <= '0;
            r_valid    <= '0;
            r_seq      <= '0;
            r_repl_cnt <= '0;
            r_refresh  <= 1'b1;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_valid    <= n_valid;
            r_seq      <= n_seq;
            r_repl_cnt <= n_repl_cnt;
            r_refresh  <= n_refresh;
            r_o_valid  <= n_o_valid;
        end
    end

    // payload: pending page, scan results, output register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page <= PAGE_BITS'(i_page_number);
        end
        r_best_idx   <= n_best_idx;
        r_best_stamp <= n_best_stamp;
        r_best_page  <= n_best_page;
        r_slot       <= n_slot;
        r_outcome    <= n_outcome;
        if (w_fire) begin
            r_o_outcome  <= r_outcome;
            r_o_frame    <= PFR_FRAME_OUT_W'(r_slot);
            r_o_ev_valid <= w_is_repl;
            r_o_ev_page  <= w_is_repl ? PFR_PAGE_IN_W'(r_best_page) : '0;
        end
    end

    pfr_frame_store #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rd_addr  (n_idx),
        .o_rd_page  (w_rd_page),
        .o_rd_stamp (w_rd_stamp),
        .i_wr       (w_wr),
        .i_wr_addr  (r_slot),
        .i_wr_page  (r_page),
        .i_wr_stamp (r_seq)
    );

    assign o_valid             = r_o_valid;
    assign o_outcome           = r_o_outcome;
    assign o_frame_index       = r_o_frame;
    assign o_evicted_valid     = r_o_ev_valid;
    assign o_evicted_page      = r_o_ev_page;
    assign o_replacement_total = r_repl_cnt;

    // an accepted transaction always starts a scan
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_SCAN))
        else $error("accepted transaction did not start a scan");

    // eviction flag agrees with the outcome code
    a_evict_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_evicted_valid == (o_outcome == PFR_OUT_REPLACE)))
        else $error("eviction flag disagrees with outcome");

    // replacement count never goes down
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_repl_cnt >= $past(r_repl_cnt)))
        else $error("replacement count decreased");

    // a fill only targets an empty frame
    a_fill_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_UPD) && (r_outcome == PFR_OUT_FILL)) |-> !r_valid[r_slot])
        else $error("fill targets a resident frame");

    // a replacement happens only with every frame resident
    a_repl_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_UPD) && w_is_repl) |-> (r_valid == '1))
        else $error("replacement with an empty frame present");

endmodule

### hdl/pfr_frame_store.sv
// Frame store: page number and stamp memories, one write and one registered read port.
// Depends on pfr_pkg for the default geometry, the stamp width and the write strobe type.
module pfr_frame_store
    import pfr_pkg::*;
#(
    parameter int FRAMES    = PFR_FRAMES,
    parameter int PAGE_BITS = PFR_PAGE_BITS,
    localparam int IDX_W    = $clog2(FRAMES)
) (
    input  logic                   i_clk,
    input  logic [IDX_W-1:0]       i_rd_addr,
    output logic [PAGE_BITS-1:0]   o_rd_page,
    output logic [PFR_STAMP_W-1:0] o_rd_stamp,
    input  t_store_wr              i_wr,
    input  logic [IDX_W-1:0]       i_wr_addr,
    input  logic [PAGE_BITS-1:0]   i_wr_page,
    input  logic [PFR_STAMP_W-1:0] i_wr_stamp
);

    logic [PAGE_BITS-1:0]   r_page_mem  [FRAMES];
    logic [PFR_STAMP_W-1:0] r_stamp_mem [FRAMES];

    // Write the selected fields of one frame
    always_ff @(posedge i_clk) begin
        if (i_wr.page_we) begin
            r_page_mem[i_wr_addr] <= i_wr_page;
        end
        if (i_wr.stamp_we) begin
            r_stamp_mem[i_wr_addr] <= i_wr_stamp;
        end
    end

    // Read one frame per cycle, data registered
    always_ff @(posedge i_clk) begin
        o_rd_page  <= r_page_mem[i_rd_addr];
        o_rd_stamp <= r_stamp_mem[i_rd_addr];
    end

endmodule
